### src/dqd_pkg.sv
// Shared constants, types and helpers for the deque with dedupe.
package dqd_pkg;

  localparam int DEPTH     = 16;
  localparam int DATA_BITS = 32;
  localparam int AW        = $clog2(DEPTH);
  localparam int CW        = $clog2(DEPTH + 1);

  typedef logic [2:0] mode_t;
  localparam mode_t MODE_PUSH_FRONT = 3'd0;
  localparam mode_t MODE_PUSH_BACK  = 3'd1;
  localparam mode_t MODE_POP_FRONT  = 3'd2;
  localparam mode_t MODE_POP_BACK   = 3'd3;
  localparam mode_t MODE_REVERSE    = 3'd4;
  localparam mode_t MODE_DEDUPE     = 3'd5;

  typedef logic [1:0] status_t;
  localparam status_t ST_DONE  = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

  typedef logic [DATA_BITS-1:0] word_t;
  typedef logic [AW-1:0]        addr_t;
  typedef logic [CW-1:0]        cnt_t;

  // physical slot of logical position pos
  function automatic addr_t phys(input addr_t front, input logic flipped, input addr_t pos);
    phys = flipped ? addr_t'(front - pos) : addr_t'(front + pos);
  endfunction

endpackage

### src/dqd_if.sv
// Input and output word channels of the deque.
interface dqd_in_if;
  logic                  valid;
  logic                  ready;
  logic [2:0]            mode;
  logic signed [31:0]    value;
  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

interface dqd_out_if;
  logic                  valid;
  logic                  ready;
  logic [1:0]            status;
  logic signed [31:0]    front_value;
  logic signed [31:0]    back_value;
  logic [4:0]            occupancy;
  logic                  is_empty;
  modport source (output valid, output status, output front_value, output back_value,
                  output occupancy, output is_empty, input ready);
  modport sink   (input valid, input status, input front_value, input back_value,
                  input occupancy, input is_empty, output ready);
endinterface

### src/double_ended_queue_with_dedupe.sv
// Bounded deque of 16 signed 32-bit words held in a ring RAM, with push/pop at
// either end, an O(1) reverse (a direction flag on the ring walk) and in-place
// duplicate removal. One word in gives one word out. Push, pop and reverse pass
// from accept to result through an execute state (the push writes the ring RAM
// there), then two reads of the ring RAM for the new front and back words,
// which are skipped when the queue is empty afterwards. The block takes the
// next word in the cycle after the result is loaded, so it cannot take a new
// word before it is through with the last one.
// Remove-duplicates walks the ring front to back; each entry is fetched and
// compared with the survivors one by one (reads of a second RAM holding the
// survivors) until one matches, and is appended there when none does; then the
// survivors are copied back to slots from 0 up.
// The result sits in an output register, so the next word is taken while it
// waits. Status: done, empty (pop/reverse/dedupe on empty), full (push rejected);
// front and back read 0 when the queue is empty.
module double_ended_queue_with_dedupe (
  input logic           clk,
  input logic           rst,
  dqd_in_if.sink        in_ch,
  dqd_out_if.source     out_ch
);

  typedef enum logic [11:0] {
    S_IDLE = 12'b000000000001,
    S_EXEC = 12'b000000000010,
    S_RDF  = 12'b000000000100,
    S_RDB  = 12'b000000001000,
    S_CAPB = 12'b000000010000,
    S_DRD  = 12'b000000100000,
    S_DW   = 12'b000001000000,
    S_DCMP = 12'b000010000000,
    S_DCHK = 12'b000100000000,
    S_CPR  = 12'b001000000000,
    S_CPW  = 12'b010000000000,
    S_FIN  = 12'b100000000000
  } state_t;

  state_t               state;
  dqd_pkg::mode_t       mode;
  dqd_pkg::word_t       value;
  dqd_pkg::addr_t       front;
  dqd_pkg::cnt_t        count;
  logic                 flipped;
  dqd_pkg::status_t     status;
  dqd_pkg::word_t       fv, bv, w;
  dqd_pkg::cnt_t        i, j, kept;

  // ring RAM ports
  logic                 s_we;
  dqd_pkg::addr_t       s_waddr, s_raddr;
  dqd_pkg::word_t       s_wdata, s_rdata;
  // survivor RAM ports
  logic                 p_we;
  dqd_pkg::addr_t       p_raddr;
  dqd_pkg::word_t       p_rdata;

  logic                 full;
  dqd_pkg::addr_t       back_pos;

  assign full     = (count == dqd_pkg::cnt_t'(dqd_pkg::DEPTH));
  assign back_pos = dqd_pkg::addr_t'(count - 1'b1);
  assign in_ch.ready = (state == S_IDLE);

  dqd_ram #(.WIDTH(dqd_pkg::DATA_BITS), .DEPTH(dqd_pkg::DEPTH)) u_ring (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  dqd_ram #(.WIDTH(dqd_pkg::DATA_BITS), .DEPTH(dqd_pkg::DEPTH)) u_kept (
    .clk(clk), .we(p_we), .waddr(kept[dqd_pkg::AW-1:0]), .wdata(w),
    .raddr(p_raddr), .rdata(p_rdata)
  );

  // RAM address and write selection
  always_comb begin
    s_we    = 1'b0;
    s_waddr = '0;
    s_wdata = value;
    s_raddr = front;
    p_we    = 1'b0;
    p_raddr = j[dqd_pkg::AW-1:0];
    case (state)
      S_EXEC: begin
        if (!full && mode == dqd_pkg::MODE_PUSH_FRONT) begin
          s_we    = 1'b1;
          s_waddr = flipped ? dqd_pkg::addr_t'(front + 1'b1) : dqd_pkg::addr_t'(front - 1'b1);
        end else if (!full && mode == dqd_pkg::MODE_PUSH_BACK) begin
          s_we    = 1'b1;
          s_waddr = dqd_pkg::phys(front, flipped, count[dqd_pkg::AW-1:0]);
        end
      end
      S_RDB:  s_raddr = dqd_pkg::phys(front, flipped, back_pos);
      S_DRD:  s_raddr = dqd_pkg::phys(front, flipped, i[dqd_pkg::AW-1:0]);
      S_DCMP: p_we    = (j == kept);
      S_CPW: begin
        s_we    = 1'b1;
        s_waddr = j[dqd_pkg::AW-1:0];
        s_wdata = p_rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      front        <= '0;
      count        <= '0;
      flipped      <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      // in S_FIN the load below decides valid on its own
      if (out_ch.valid && out_ch.ready && state != S_FIN) out_ch.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            mode  <= in_ch.mode;
            value <= in_ch.value;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          status <= dqd_pkg::ST_DONE;
          state  <= S_RDF;
          case (mode)
            dqd_pkg::MODE_PUSH_FRONT: begin
              if (full) status <= dqd_pkg::ST_FULL;
              else begin
                front <= s_waddr;
                count <= count + 1'b1;
              end
            end
            dqd_pkg::MODE_PUSH_BACK: begin
              if (full) status <= dqd_pkg::ST_FULL;
              else count <= count + 1'b1;
            end
            dqd_pkg::MODE_POP_FRONT: begin
              if (count == '0) status <= dqd_pkg::ST_EMPTY;
              else begin
                front <= dqd_pkg::phys(front, flipped, dqd_pkg::addr_t'(1));
                count <= count - 1'b1;
              end
            end
            dqd_pkg::MODE_POP_BACK: begin
              if (count == '0) status <= dqd_pkg::ST_EMPTY;
              else count <= count - 1'b1;
            end
            dqd_pkg::MODE_REVERSE: begin
              if (count == '0) status <= dqd_pkg::ST_EMPTY;
              else begin
                front   <= dqd_pkg::phys(front, flipped, back_pos);
                flipped <= ~flipped;
              end
            end
            dqd_pkg::MODE_DEDUPE: begin
              if (count == '0) status <= dqd_pkg::ST_EMPTY;
              else begin
                i     <= '0;
                kept  <= '0;
                state <= S_DRD;
              end
            end
            default: ;
          endcase
        end
        S_RDF: begin
          if (count == '0) begin
            fv    <= '0;
            bv    <= '0;
            state <= S_FIN;
          end else state <= S_RDB;
        end
        S_RDB: begin
          fv    <= s_rdata;
          state <= S_CAPB;
        end
        S_CAPB: begin
          bv    <= s_rdata;
          state <= S_FIN;
        end
        // dedupe: fetch entry i
        S_DRD: state <= S_DW;
        S_DW: begin
          w     <= s_rdata;
          j     <= '0;
          state <= S_DCMP;
        end
        // compare with survivor j, or append when none matched
        S_DCMP: begin
          if (j == kept) begin
            kept <= kept + 1'b1;
            i    <= i + 1'b1;
            if (i + 1'b1 == count) begin
              j     <= '0;
              state <= S_CPR;
            end else state <= S_DRD;
          end else state <= S_DCHK;
        end
        S_DCHK: begin
          if (p_rdata == w) begin
            i <= i + 1'b1;
            if (i + 1'b1 == count) begin
              j     <= '0;
              state <= S_CPR;
            end else state <= S_DRD;
          end else begin
            j     <= j + 1'b1;
            state <= S_DCMP;
          end
        end
        // copy survivors back to slots 0 and up
        S_CPR: state <= S_CPW;
        S_CPW: begin
          if (j + 1'b1 == kept) begin
            front   <= '0;
            flipped <= 1'b0;
            count   <= kept;
            state   <= S_RDF;
          end else begin
            j     <= j + 1'b1;
            state <= S_CPR;
          end
        end
        S_FIN: begin
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.valid       <= 1'b1;
            out_ch.status      <= status;
            out_ch.front_value <= fv;
            out_ch.back_value  <= bv;
            out_ch.occupancy   <= count;
            out_ch.is_empty    <= (count == '0);
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### src/dqd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dqd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### src/dqd_checker.sv
// Port-level checks on the deque results, bound to the top level.
module dqd_checker (
  input logic               clk,
  input logic               rst,
  input logic               o_valid,
  input logic               o_ready,
  input logic [1:0]         o_status,
  input logic signed [31:0] o_front,
  input logic signed [31:0] o_back,
  input logic [4:0]         o_occ,
  input logic               o_empty
);
  a_occ_range: assert property (@(posedge clk) disable iff (rst)
    o_valid |-> o_occ <= 5'(dqd_pkg::DEPTH)) else $error("occupancy over depth");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    o_valid |-> o_empty == (o_occ == 5'd0)) else $error("empty flag mismatch");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    o_valid && o_empty |-> o_front == 32'sd0 && o_back == 32'sd0)
    else $error("nonzero ends on empty queue");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    o_valid |-> o_status != 2'd3) else $error("bad status code");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    o_valid && !o_ready |=> o_valid && $stable(o_occ)) else $error("stalled word dropped");
endmodule

bind double_ended_queue_with_dedupe dqd_checker u_dqd_checker (
  .clk(clk), .rst(rst),
  .o_valid(out_ch.valid), .o_ready(out_ch.ready), .o_status(out_ch.status),
  .o_front(out_ch.front_value), .o_back(out_ch.back_value),
  .o_occ(out_ch.occupancy), .o_empty(out_ch.is_empty)
);
